@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by tsw_div and tsw_ctrl.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ hdl/tsw_pkg.sv @@
// ----------------------------------------------------------------------------
// tsw_pkg
// Types, constants and helper functions for the triangle span walker.
// ----------------------------------------------------------------------------
package tsw_pkg;

  localparam int FRAC         = 16;
  localparam int COL_W        = 11;
  localparam int ROW_W        = 10;
  localparam int CLR_W        = 8;
  localparam int POS_W        = 12 + FRAC;
  localparam int DIV_W        = COL_W + FRAC;
  localparam int CNT_W        = $clog2(DIV_W + 1);
  localparam int CEIL_W       = POS_W - FRAC + 1;
  localparam int SCREEN_WIDTH = 1024;
  localparam int CLIP_LIM     = (SCREEN_WIDTH < 2047) ? SCREEN_WIDTH : 2047;
  localparam logic MODE_LOAD  = 1'b0;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef enum logic [1:0] {ST_IDLE, ST_DIV_GO, ST_DIV_WAIT, ST_SETUP} state_t;
  typedef enum logic [1:0] {SEL_SHORT, SEL_LONG, SEL_BOT} div_sel_t;

  typedef struct packed {
    logic     load;
    logic     step;
    logic     div_start;
    logic     setup;
    div_sel_t div_sel;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  typedef struct packed {
    logic [COL_W-1:0] ax;
    logic [ROW_W-1:0] ay;
    logic [COL_W-1:0] bx;
    logic [ROW_W-1:0] by;
    logic [COL_W-1:0] cx;
    logic [ROW_W-1:0] cy;
    logic [CLR_W-1:0] red;
    logic [CLR_W-1:0] green;
    logic [CLR_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic             row_present;
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] span_first;
    logic [COL_W-1:0] span_limit;
    logic             span_nonempty;
    logic             final_row;
    logic [CLR_W-1:0] red;
    logic [CLR_W-1:0] green;
    logic [CLR_W-1:0] blue;
  } out_item_t;

  function automatic logic signed [POS_W-1:0] sat_add(
    input logic signed [POS_W-1:0] a,
    input logic signed [POS_W-1:0] b
  );
    logic signed [POS_W:0] s;
    s = {a[POS_W-1], a} + {b[POS_W-1], b};
    if (s[POS_W] != s[POS_W-1]) return s[POS_W] ? POS_MIN : POS_MAX;
    return s[POS_W-1:0];
  endfunction

  function automatic logic [COL_W-1:0] clip_col(input logic signed [CEIL_W-1:0] c);
    if (c < 0) return '0;
    if (c > CEIL_W'(CLIP_LIM)) return COL_W'(CLIP_LIM);
    return c[COL_W-1:0];
  endfunction

endpackage

@@ hdl/tsw_if.sv @@
// ----------------------------------------------------------------------------
// tsw_in_if / tsw_out_if
// Valid/ready channels for vertex beats and span beats.
// ----------------------------------------------------------------------------
interface tsw_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [10:0] vert_a_x;
  logic [9:0]  vert_a_y;
  logic [10:0] vert_b_x;
  logic [9:0]  vert_b_y;
  logic [10:0] vert_c_x;
  logic [9:0]  vert_c_y;
  logic [7:0]  fill_red;
  logic [7:0]  fill_green;
  logic [7:0]  fill_blue;
  modport source (output valid, mode, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x,
                  vert_c_y, fill_red, fill_green, fill_blue, input ready);
  modport sink (input valid, mode, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x,
                vert_c_y, fill_red, fill_green, fill_blue, output ready);
endinterface

interface tsw_out_if;
  logic        valid;
  logic        ready;
  logic        row_present;
  logic [9:0]  row_index;
  logic [10:0] span_first;
  logic [10:0] span_limit;
  logic        span_nonempty;
  logic        final_row;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  modport source (output valid, row_present, row_index, span_first, span_limit,
                  span_nonempty, final_row, out_red, out_green, out_blue, input ready);
  modport sink (input valid, row_present, row_index, span_first, span_limit,
                span_nonempty, final_row, out_red, out_green, out_blue, output ready);
endinterface

@@ hdl/tsw_div.sv @@
// ----------------------------------------------------------------------------
// tsw_div
// Restoring divider, one quotient bit per cycle, for edge slopes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tsw_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [tsw_pkg::DIV_W-1:0]         mag,
  input  logic [tsw_pkg::ROW_W-1:0]         divisor,
  input  logic                              neg,
  output logic                              done,
  output logic signed [tsw_pkg::POS_W-1:0]  quot
);
  import tsw_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [ROW_W-1:0] rem;
  logic [DIV_W-1:0] q;
  logic [ROW_W-1:0] dvs;
  logic             negr;
  logic [ROW_W:0]   shifted;
  logic [ROW_W:0]   rem_next;
  logic             ge;

  always_comb begin
    shifted  = {rem, q[DIV_W-1]};
    ge       = shifted >= {1'b0, dvs};
    rem_next = ge ? (shifted - {1'b0, dvs}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        q    <= mag;
        dvs  <= divisor;
        negr <= neg;
      end else if (busy) begin
        rem <= rem_next[ROW_W-1:0];
        q   <= {q[DIV_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (dvs == '0) quot = '0;
    else if (negr) quot = -signed'({1'b0, q});
    else quot = signed'({1'b0, q});
  end

  `ASSERT_CLK(a_done_after_busy, clk, rst, done |-> $past(busy), "done without busy")
  `ASSERT_CLK(a_start_idle, clk, rst, start |-> !busy, "start while busy")
  `ASSERT_CLK(a_cnt_range, clk, rst, busy |-> (cnt < CNT_W'(DIV_W)), "count overrun")

endmodule

@@ hdl/tsw_dp.sv @@
// ----------------------------------------------------------------------------
// tsw_dp
// Datapath: vertex sort, slope storage, edge walk and span register.
// ----------------------------------------------------------------------------
module tsw_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  tsw_pkg::in_item_t    item,
  input  tsw_pkg::cmd_t        cmd,
  output tsw_pkg::status_t     status,
  output tsw_pkg::out_item_t   res
);
  import tsw_pkg::*;

  logic [COL_W-1:0] tx, mx, bx;
  logic [ROW_W-1:0] ty, my, by;
  logic [3*CLR_W-1:0] colour;
  logic signed [POS_W-1:0] s_short, s_long, s_bot;
  logic signed [POS_W-1:0] lpos, rpos, lslope, rslope;
  logic [ROW_W-1:0] row;
  logic in_bot, short_left, active;

  logic [COL_W-1:0] sax, sbx, scx, t_x;
  logic [ROW_W-1:0] say, sby, scy, t_y;

  logic [COL_W-1:0] xa, xb;
  logic [ROW_W-1:0] ya, yb;
  logic signed [COL_W:0] dx;
  logic [COL_W-1:0] magx;
  logic div_done;
  logic signed [POS_W-1:0] quot;

  logic signed [CEIL_W-1:0] fl, cl;
  logic signed [POS_W:0] rsum;
  logic [COL_W-1:0] first, limit;
  logic fin;
  logic [ROW_W-1:0] row_next;
  logic signed [POS_W-1:0] txf, mxf;

  always_comb begin
    t_x = '0; t_y = '0;
    sax = item.ax; say = item.ay;
    sbx = item.bx; sby = item.by;
    scx = item.cx; scy = item.cy;
    if (sby < say) begin
      t_y = sby; sby = say; say = t_y; t_x = sbx; sbx = sax; sax = t_x;
    end
    if (scy < say) begin
      t_y = scy; scy = say; say = t_y; t_x = scx; scx = sax; sax = t_x;
    end
    if (sby < scy) begin
      t_y = scy; scy = sby; sby = t_y; t_x = scx; scx = sbx; sbx = t_x;
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      SEL_SHORT: begin xa = tx; ya = ty; xb = mx; yb = my; end
      SEL_LONG:  begin xa = tx; ya = ty; xb = bx; yb = by; end
      SEL_BOT:   begin xa = mx; ya = my; xb = bx; yb = by; end
      default:   begin xa = tx; ya = ty; xb = bx; yb = by; end
    endcase
    dx   = signed'({1'b0, xb}) - signed'({1'b0, xa});
    magx = dx[COL_W] ? COL_W'(-dx) : dx[COL_W-1:0];
  end

  tsw_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .mag     ({magx, {FRAC{1'b0}}}),
    .divisor (yb - ya),
    .neg     (dx[COL_W]),
    .done    (div_done),
    .quot    (quot)
  );

  assign status.div_done = div_done;

  always_comb begin
    fl       = {lpos[POS_W-1], lpos[POS_W-1:FRAC]};
    rsum     = {rpos[POS_W-1], rpos} + (POS_W+1)'((1 << FRAC) - 1);
    cl       = rsum[POS_W:FRAC];
    first    = clip_col(fl);
    limit    = clip_col(cl);
    fin      = ({1'b0, row} + 1'b1) == {1'b0, by};
    row_next = row + 1'b1;
    txf      = signed'({1'b0, tx, {FRAC{1'b0}}});
    mxf      = signed'({1'b0, mx, {FRAC{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx <= '0; ty <= '0; mx <= '0; my <= '0; bx <= '0; by <= '0;
      colour <= '0; s_short <= '0; s_long <= '0; s_bot <= '0;
      lpos <= '0; rpos <= '0; lslope <= '0; rslope <= '0;
      row <= '0; in_bot <= 1'b0; short_left <= 1'b0; active <= 1'b0;
    end else begin
      if (cmd.load) begin
        tx <= sax; ty <= say; mx <= scx; my <= scy; bx <= sbx; by <= sby;
        colour <= {item.red, item.green, item.blue};
      end
      if (div_done) begin
        unique case (cmd.div_sel)
          SEL_SHORT: s_short <= quot;
          SEL_LONG:  s_long  <= quot;
          SEL_BOT:   s_bot   <= quot;
          default:   s_bot   <= quot;
        endcase
      end
      if (cmd.setup) begin
        row    <= ty;
        active <= ty < by;
        in_bot <= ty == my;
        if (ty == my) begin
          short_left <= mx < tx;
          if (mx < tx) begin
            lpos <= mxf; lslope <= s_bot; rpos <= txf; rslope <= s_long;
          end else begin
            lpos <= txf; lslope <= s_long; rpos <= mxf; rslope <= s_bot;
          end
        end else begin
          short_left <= s_short < s_long;
          lpos   <= txf;
          rpos   <= txf;
          lslope <= (s_short < s_long) ? s_short : s_long;
          rslope <= (s_short < s_long) ? s_long : s_short;
        end
      end
      if (cmd.step && active) begin
        lpos <= sat_add(lpos, lslope);
        rpos <= sat_add(rpos, rslope);
        row  <= row_next;
        if (!in_bot && row_next == my) begin
          in_bot <= 1'b1;
          if (short_left) lslope <= s_bot;
          else rslope <= s_bot;
        end
        if (fin) active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      if (active) begin
        res.row_present   <= 1'b1;
        res.row_index     <= row;
        res.span_first    <= first;
        res.span_limit    <= limit;
        res.span_nonempty <= first < limit;
        res.final_row     <= fin;
        res.red           <= colour[3*CLR_W-1:2*CLR_W];
        res.green         <= colour[2*CLR_W-1:CLR_W];
        res.blue          <= colour[CLR_W-1:0];
      end else begin
        res <= '0;
      end
    end
  end

endmodule

@@ hdl/tsw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsw_ctrl
// Controller: handshakes, slope division sequence and triangle setup.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tsw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_mode,
  input  logic              out_ready,
  output logic              in_ready,
  output logic              out_valid,
  output tsw_pkg::cmd_t     cmd,
  input  tsw_pkg::status_t  status
);
  import tsw_pkg::*;

  state_t   state, state_next;
  div_sel_t sel, sel_next;
  logic     out_valid_next;
  logic     accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sel       <= SEL_SHORT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sel       <= sel_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    sel_next       = sel;
    cmd            = '0;
    cmd.div_sel    = sel;
    in_ready       = (state == ST_IDLE) && (!out_valid || out_ready);
    accept         = in_valid && in_ready;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_LOAD) begin
            cmd.load   = 1'b1;
            sel_next   = SEL_SHORT;
            state_next = ST_DIV_GO;
          end else begin
            cmd.step       = 1'b1;
            out_valid_next = 1'b1;
          end
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          unique case (sel)
            SEL_SHORT: begin sel_next = SEL_LONG; state_next = ST_DIV_GO; end
            SEL_LONG:  begin sel_next = SEL_BOT;  state_next = ST_DIV_GO; end
            default:   state_next = ST_SETUP;
          endcase
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `ASSERT_CLK(a_load_starts_div, clk, rst,
              (accept && in_mode == MODE_LOAD) |=> state == ST_DIV_GO, "no division")
  `ASSERT_CLK(a_step_gives_beat, clk, rst,
              (accept && in_mode != MODE_LOAD) |=> out_valid, "step gave no beat")
  `ASSERT_CLK(a_done_in_wait, clk, rst,
              status.div_done |-> state == ST_DIV_WAIT, "division done outside wait")
  `ASSERT_ALWAYS(a_reset_idle, clk,
                 $past(rst) |-> (state == ST_IDLE && !out_valid), "reset left control busy")

endmodule

@@ hdl/triangle_scanline_span_walker.sv @@
// ----------------------------------------------------------------------------
// triangle_scanline_span_walker
// Flat-fill triangle walker: one span beat per step beat.
// Step beat: the span beat is valid the next cycle after acceptance; one step
//   per cycle while the output is taken.
// Load beat: after acceptance the block is busy with three serial slope
//   divisions plus setup; the next beat is taken back in idle after setup.
// Reset: synchronous, clears control and walker state; nothing to draw.
// ----------------------------------------------------------------------------
module triangle_scanline_span_walker (
  input  logic      clk,
  input  logic      rst,
  tsw_in_if.sink    in_ch,
  tsw_out_if.source out_ch
);
  import tsw_pkg::*;

  cmd_t      cmd;
  status_t   status;
  in_item_t  item;
  out_item_t res;

  assign item = '{ax: in_ch.vert_a_x, ay: in_ch.vert_a_y,
                  bx: in_ch.vert_b_x, by: in_ch.vert_b_y,
                  cx: in_ch.vert_c_x, cy: in_ch.vert_c_y,
                  red: in_ch.fill_red, green: in_ch.fill_green, blue: in_ch.fill_blue};

  tsw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .out_ready (out_ch.ready),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd),
    .status    (status)
  );

  tsw_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .res    (res)
  );

  assign out_ch.row_present   = res.row_present;
  assign out_ch.row_index     = res.row_index;
  assign out_ch.span_first    = res.span_first;
  assign out_ch.span_limit    = res.span_limit;
  assign out_ch.span_nonempty = res.span_nonempty;
  assign out_ch.final_row     = res.final_row;
  assign out_ch.out_red       = res.red;
  assign out_ch.out_green     = res.green;
  assign out_ch.out_blue      = res.blue;

endmodule
